/* design/rwmc_pkg.sv */
`default_nettype none
package rwmc_pkg;
  localparam int VALUE_BITS = 12;
  localparam int MAX_ITEMS  = 65536;
  localparam int TREE_SIZE  = 1 << VALUE_BITS;
  localparam int CNT_W      = 17;
  localparam int SUM_W      = 28;
  localparam int COST_W     = 48;
  localparam int REG_W      = 16;
  localparam int IDX_W      = 1;
  localparam logic [IDX_W-1:0] REG_COST_RAISE = 1'b0;
  localparam logic [IDX_W-1:0] REG_COST_LOWER = 1'b1;
  localparam int NODE_W     = VALUE_BITS + 1;
  localparam int NUM_W      = REG_W + CNT_W;
  localparam int DEN_W      = REG_W + 1;
  localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
  localparam int STEP_W     = $clog2(VALUE_BITS + 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_INS_RD, ST_INS_WR, ST_DIV, ST_RANK,
    ST_DSC_RD, ST_DSC_CHK, ST_MUL1, ST_MUL2, ST_MUL3, ST_DONE
  } state_t;
endpackage
`default_nettype wire

/* design/running_weighted_median_cost_top.sv */
// Running weighted median cost.
// Input channel: sample_value with valid/ready. Output channel: total_cost,
// target_value and rejected with out_valid/out_ready; one result per item.
// Configuration: cfg_we/cfg_index/cfg_data write cost_raise (index 0) and
// cost_lower (index 1); write only while idle.
// State lives in two synchronous RAMs (count tree, sum tree) indexed by
// value, with a registered read port.
// Per item: the insert takes a read and a write state per tree level
// (VALUE_BITS+1 levels at most), then the bit-serial rank division, the
// descent with a read and a check state per level (VALUE_BITS levels), and
// the cost arithmetic in ST_MUL1, ST_MUL2 and ST_MUL3. The tree RAM port sets
// the insert and descent pace; the divider sets the rank time.
// A rejected item (store full) goes straight from idle to the done state.
// After reset a clearing pass writes zero to every tree entry, one per cycle,
// while in_ready stays low.
// One item is processed at a time. The result sits in an output register;
// if the receiver stalls, the block holds it and takes no new item until it
// is taken.
`default_nettype none
module running_weighted_median_cost_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [rwmc_pkg::VALUE_BITS-1:0] sample_value,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [rwmc_pkg::COST_W-1:0] total_cost,
  output logic [rwmc_pkg::VALUE_BITS-1:0] target_value,
  output logic rejected,
  input  wire logic cfg_we,
  input  wire logic [rwmc_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [rwmc_pkg::REG_W-1:0] cfg_data
);
  import rwmc_pkg::*;

  logic [CNT_W-1:0] cnt_mem [0:TREE_SIZE];
  logic [SUM_W-1:0] sum_mem [0:TREE_SIZE];

  state_t state, state_next;
  logic [REG_W-1:0] cost_raise, cost_lower;
  logic [CNT_W-1:0] items_seen;
  logic [SUM_W-1:0] running_total;
  logic [VALUE_BITS-1:0] v;
  logic [NODE_W-1:0] node;
  logic [CNT_W-1:0] cnt_rd;
  logic [SUM_W-1:0] sum_rd;
  logic mem_we;
  logic [NODE_W-1:0] mem_addr;
  logic [CNT_W-1:0] cnt_wd;
  logic [SUM_W-1:0] sum_wd;

  // divider
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0] remr;
  logic [DEN_W-1:0] den;
  logic [DIV_CNT_W-1:0] dcnt;
  logic [DEN_W:0] rtrial;

  logic [CNT_W-1:0] k, rem;
  logic [SUM_W-1:0] low_sum;
  logic [STEP_W-1:0] lvl;
  logic [NODE_W-1:0] nxt;
  logic [SUM_W+CNT_W-1:0] p0, p1;
  logic [SUM_W+CNT_W-1:0] above, below;
  logic [63:0] m0, m1;
  logic [64:0] csum;

  assign nxt = node + (NODE_W'(1) << lvl);
  assign rtrial = {remr[DEN_W-1:0], quo[NUM_W-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_addr] <= cnt_wd;
      sum_mem[mem_addr] <= sum_wd;
    end
    cnt_rd <= cnt_mem[mem_addr];
    sum_rd <= sum_mem[mem_addr];
  end

  always_comb begin
    state_next = state;
    mem_we = 1'b0;
    mem_addr = node;
    cnt_wd = cnt_rd + CNT_W'(1);
    sum_wd = sum_rd + SUM_W'(v);
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        cnt_wd = '0;
        sum_wd = '0;
        if (node == NODE_W'(TREE_SIZE)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = !out_valid;
        if (in_valid && !out_valid) begin
          if (items_seen >= CNT_W'(MAX_ITEMS)) state_next = ST_DONE;
          else state_next = ST_INS_RD;
        end
      end
      ST_INS_RD: state_next = ST_INS_WR;
      ST_INS_WR: begin
        mem_we = 1'b1;
        if (node + (node & (~node + NODE_W'(1))) > NODE_W'(TREE_SIZE) ||
            node + (node & (~node + NODE_W'(1))) == '0)
          state_next = ST_DIV;
        else state_next = ST_INS_RD;
      end
      ST_DIV: if (dcnt == DIV_CNT_W'(NUM_W)) state_next = ST_RANK;
      ST_RANK: state_next = ST_DSC_RD;
      ST_DSC_RD: begin
        mem_addr = nxt;
        state_next = ST_DSC_CHK;
      end
      ST_DSC_CHK: if (lvl == '0) state_next = ST_MUL1; else state_next = ST_DSC_RD;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MUL3;
      ST_MUL3: state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      node <= '0;
      out_valid <= 1'b0;
      cost_raise <= REG_W'(1);
      cost_lower <= REG_W'(1);
      items_seen <= '0;
      running_total <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == REG_COST_RAISE) cost_raise <= cfg_data;
        if (cfg_index == REG_COST_LOWER) cost_lower <= cfg_data;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: node <= node + NODE_W'(1);
        ST_IDLE: if (in_valid && !out_valid) begin
          v <= sample_value;
          node <= NODE_W'(sample_value) + NODE_W'(1);
          rejected <= items_seen >= CNT_W'(MAX_ITEMS);
          total_cost <= '0;
          target_value <= '0;
        end
        ST_INS_WR: begin
          node <= node + (node & (~node + NODE_W'(1)));
          if (state_next == ST_DIV) begin
            items_seen <= items_seen + CNT_W'(1);
            running_total <= running_total + SUM_W'(v);
            quo <= NUM_W'(cost_lower) * NUM_W'(items_seen + CNT_W'(1));
            den <= DEN_W'(cost_raise) + DEN_W'(cost_lower);
            remr <= '0;
            dcnt <= '0;
          end
        end
        ST_DIV: if (dcnt != DIV_CNT_W'(NUM_W)) begin
          dcnt <= dcnt + DIV_CNT_W'(1);
          if (!rtrial[DEN_W]) begin
            remr <= rtrial;
            quo <= {quo[NUM_W-2:0], 1'b1};
          end else begin
            remr <= {remr[DEN_W-1:0], quo[NUM_W-1]};
            quo <= {quo[NUM_W-2:0], 1'b0};
          end
        end
        ST_RANK: begin
          // ceil: quotient plus one if remainder nonzero
          if (den == '0 || quo == '0) k <= CNT_W'(1);
          else if (CNT_W'(quo + NUM_W'(remr != '0)) > items_seen) k <= items_seen;
          else k <= CNT_W'(quo + NUM_W'(remr != '0));
          if (den == '0 || quo == '0) rem <= CNT_W'(1);
          else if (CNT_W'(quo + NUM_W'(remr != '0)) > items_seen) rem <= items_seen;
          else rem <= CNT_W'(quo + NUM_W'(remr != '0));
          node <= '0;
          low_sum <= '0;
          lvl <= STEP_W'(VALUE_BITS - 1);
        end
        ST_DSC_CHK: begin
          if (rem > cnt_rd) begin
            node <= nxt;
            rem <= rem - cnt_rd;
            low_sum <= low_sum + sum_rd;
          end
          if (lvl != '0) lvl <= lvl - STEP_W'(1);
        end
        ST_MUL1: begin
          p0 <= (SUM_W+CNT_W)'(rem) * (SUM_W+CNT_W)'(node);
          p1 <= (SUM_W+CNT_W)'(k) * (SUM_W+CNT_W)'(node);
          above <= (SUM_W+CNT_W)'(items_seen - k) * (SUM_W+CNT_W)'(node);
        end
        ST_MUL2: begin
          above <= p1 - ((SUM_W+CNT_W)'(low_sum) + p0);
          below <= (SUM_W+CNT_W)'(running_total) - ((SUM_W+CNT_W)'(low_sum) + p0)
                   - above;
        end
        ST_MUL3: begin
          m0 <= 64'(cost_raise) * 64'(above);
          m1 <= 64'(cost_lower) * 64'(below);
        end
        ST_DONE: begin
          out_valid <= 1'b1;
          if (!rejected) begin
            target_value <= node[VALUE_BITS-1:0];
            total_cost <= (csum > 65'({COST_W{1'b1}})) ? {COST_W{1'b1}}
                                                        : csum[COST_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign csum = 65'(m0) + 65'(m1);
endmodule
`default_nettype wire

/* test/rwmc_checker.sv */
`default_nettype none
module rwmc_checker
  import rwmc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire logic [VALUE_BITS-1:0] sample_value,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic [COST_W-1:0]     total_cost,
  input  wire logic [VALUE_BITS-1:0] target_value,
  input  wire logic                  rejected,
  input  wire logic                  cfg_we,
  input  wire logic [IDX_W-1:0]      cfg_index,
  input  wire logic [REG_W-1:0]      cfg_data,
  output int                         errors,
  output int                         pending
);
  localparam longint unsigned COST_SAT = 64'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [COST_W-1:0]     cost;
    logic [VALUE_BITS-1:0] target;
    logic                  rej;
  } median_result_t;

  median_result_t result_q[$];
  longint unsigned cnt_tree[0:TREE_SIZE];
  longint unsigned sum_tree[0:TREE_SIZE];
  longint unsigned held, total;
  longint unsigned raise_cost, lower_cost;

  assign pending = result_q.size();

  function automatic median_result_t median_cost(input logic [VALUE_BITS-1:0] v);
    median_result_t r;
    longint unsigned i, k, den, rem, low_sum, t, above, below, c;
    int node, pos, step;
    r = '0;
    if (held >= MAX_ITEMS) begin
      r.rej = 1'b1;
      return r;
    end
    node = int'(v) + 1;
    while (node <= TREE_SIZE) begin
      cnt_tree[node] += 1;
      sum_tree[node] += 64'(v);
      node += node & (-node);
    end
    held += 1;
    total += 64'(v);
    i = held;
    den = raise_cost + lower_cost;
    k = (den == 0) ? 1 : (lower_cost * i + den - 1) / den;
    if (k < 1) k = 1;
    if (k > i) k = i;
    pos = 0;
    rem = k;
    low_sum = 0;
    for (step = TREE_SIZE >> 1; step != 0; step >>= 1) begin
      if (pos + step <= TREE_SIZE && rem > cnt_tree[pos + step]) begin
        pos += step;
        rem -= cnt_tree[pos];
        low_sum += sum_tree[pos];
      end
    end
    t = pos;
    low_sum += rem * t;
    above = k * t - low_sum;
    below = (total - low_sum) - (i - k) * t;
    c = raise_cost * above + lower_cost * below;
    if (c > COST_SAT) c = COST_SAT;
    r.cost = c[COST_W-1:0];
    r.target = t[VALUE_BITS-1:0];
    return r;
  endfunction

  initial begin
    errors = 0;
    held = 0;
    total = 0;
    raise_cost = 1;
    lower_cost = 1;
    for (int n = 0; n <= TREE_SIZE; n++) begin
      cnt_tree[n] = 0;
      sum_tree[n] = 0;
    end
  end

  always @(posedge clk) begin
    median_result_t e;
    if (!rst) begin
      if (cfg_we) begin
        if (cfg_index == REG_COST_RAISE) raise_cost = 64'(cfg_data);
        else if (cfg_index == REG_COST_LOWER) lower_cost = 64'(cfg_data);
      end
      if (in_valid && in_ready) result_q.push_back(median_cost(sample_value));
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result with no item pending");
          errors++;
        end else begin
          e = result_q.pop_front();
          if (total_cost !== e.cost) begin
            $error("total_cost: expected %0d, got %0d", e.cost, total_cost);
            errors++;
          end
          if (target_value !== e.target) begin
            $error("target_value: expected %0d, got %0d", e.target, target_value);
            errors++;
          end
          if (rejected !== e.rej) begin
            $error("rejected: expected %0d, got %0d", e.rej, rejected);
            errors++;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

/* test/tb.sv */
`default_nettype none
module tb;
  import rwmc_pkg::*;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, rejected;
  logic [VALUE_BITS-1:0] sample_value, target_value;
  logic [COST_W-1:0] total_cost;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;
  int errors, pending;
  logic steady;
  int stall_left;
  longint cycles;

  running_weighted_median_cost_top dut (.*);
  rwmc_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd20_000_000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst || steady) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) < 6) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                : $urandom_range(0, 3);
    end
  end

  task automatic send_sample(input logic [VALUE_BITS-1:0] v);
    int gap;
    gap = steady ? 0 : ($urandom_range(0, 9) == 0) ? $urandom_range(10, 150)
                                                   : $urandom_range(0, 2);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_costs(input logic [REG_W-1:0] up, input logic [REG_W-1:0] down);
    cfg_we <= 1'b1;
    cfg_index <= REG_COST_RAISE;
    cfg_data <= up;
    @(posedge clk);
    cfg_index <= REG_COST_LOWER;
    cfg_data <= down;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value(input int mode);
    case (mode)
      0: return VALUE_BITS'($urandom_range(0, 15));
      1: return VALUE_BITS'($urandom_range(TREE_SIZE - 16, TREE_SIZE - 1));
      2: return ($urandom_range(0, 1) != 0) ? '0 : VALUE_BITS'(TREE_SIZE - 1);
      default: return VALUE_BITS'($urandom_range(0, TREE_SIZE - 1));
    endcase
  endfunction

  initial begin
    logic [REG_W-1:0] up_tab[9];
    logic [REG_W-1:0] down_tab[9];
    cycles = 0;
    rst = 1'b1;
    steady = 1'b0;
    in_valid = 1'b0;
    sample_value = '0;
    cfg_we = 1'b0;
    cfg_index = REG_COST_RAISE;
    cfg_data = '0;
    out_ready = 1'b0;
    stall_left = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes under reset costs
    foreach (up_tab[n]) begin
      up_tab[n] = REG_W'($urandom_range(1, 65535));
      down_tab[n] = REG_W'($urandom_range(1, 65535));
    end
    up_tab[0] = REG_W'(1);     down_tab[0] = REG_W'(1);
    up_tab[1] = REG_W'(65535); down_tab[1] = REG_W'(1);
    up_tab[2] = REG_W'(1);     down_tab[2] = REG_W'(65535);
    up_tab[3] = REG_W'(65535); down_tab[3] = REG_W'(65535);
    up_tab[4] = REG_W'(5);     down_tab[4] = REG_W'(0);
    up_tab[5] = REG_W'(0);     down_tab[5] = REG_W'(0);
    up_tab[6] = REG_W'(0);     down_tab[6] = REG_W'(9);

    send_sample('0);
    send_sample(VALUE_BITS'(TREE_SIZE - 1));
    send_sample('0);
    send_sample(VALUE_BITS'(TREE_SIZE - 1));
    send_sample(VALUE_BITS'(2048));
    send_sample(VALUE_BITS'(1));
    send_sample(VALUE_BITS'(TREE_SIZE - 2));
    send_sample(12'h555);
    send_sample(12'hAAA);
    repeat (3) send_sample(VALUE_BITS'(7));
    drain();

    foreach (up_tab[p]) begin
      set_costs(up_tab[p], down_tab[p]);
      steady <= (p == 3);
      repeat (155) send_sample(pick_value($urandom_range(0, 5)));
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
design/rwmc_pkg.sv
design/running_weighted_median_cost_top.sv
test/rwmc_checker.sv
test/tb.sv
